// ===== rtl/core/plg_pkg.sv =====
// Shared widths, the start index reset value and controller/datapath interface types for the goal selector.
`default_nettype none

package plg_pkg;

  localparam int PADDR_W = 4;
  localparam int DATA_W  = 32;
  localparam int STEP_W  = 10;
  localparam int TDIST_W = 31;
  localparam int START_W = 10;
  localparam int POS_W   = 10;
  localparam int OUT_W   = 32;

  localparam logic [START_W-1:0] START_RESET = 10'd0;

  typedef struct packed {
    logic point_wr;
    logic pose_load;
    logic mem_rd;
    logic advance;
    logic clamp_last;
    logic emit;
  } plg_cmd_t;

  typedef struct packed {
    logic path_valid;
    logic too_close;
    logic past_end;
    logic out_free;
  } plg_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/plg_ctrl.sv =====
// Controller state machine that sequences point writes and the goal search.
`default_nettype none

module plg_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire               func,
  input  plg_pkg::plg_sts_t sts,
  output plg_pkg::plg_cmd_t cmd
);

  localparam logic FUNC_POINT = 1'b0;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_DIFF  = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_CMP   = 3'd4;
  localparam logic [2:0] ST_FETCH = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (func == FUNC_POINT) begin
            cmd.point_wr = 1'b1;
          end else if (sts.path_valid) begin
            cmd.pose_load = 1'b1;
            state_next    = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.mem_rd = 1'b1;
        state_next = ST_DIFF;
      end
      ST_DIFF: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (!sts.too_close) begin
          state_next = ST_DONE;
        end else if (sts.past_end) begin
          cmd.clamp_last = 1'b1;
          state_next     = ST_FETCH;
        end else begin
          cmd.advance = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_FETCH: begin
        cmd.mem_rd = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/plg_dp.sv =====
// Datapath with the point store, goal index, squared-distance pipeline and result register.
`default_nettype none

module plg_dp #(
  parameter int MAX_POINTS  = 1024,
  parameter int COORD_WIDTH = 32
) (
  input  wire                                clk,
  input  wire                                rst,
  input  plg_pkg::plg_cmd_t                  cmd,
  output plg_pkg::plg_sts_t                  sts,
  input  wire  [COORD_WIDTH-1:0]             coord_x,
  input  wire  [COORD_WIDTH-1:0]             coord_y,
  input  wire                                path_last,
  input  wire  [plg_pkg::STEP_W-1:0]         step_size,
  input  wire  [plg_pkg::TDIST_W-1:0]        target_distance,
  input  wire  [plg_pkg::START_W-1:0]        start_index,
  input  wire                                start_load,
  input  wire                                out_ready,
  output logic                               out_valid,
  output logic signed [plg_pkg::OUT_W-1:0]   goal_x,
  output logic signed [plg_pkg::OUT_W-1:0]   goal_y,
  output logic [plg_pkg::POS_W-1:0]          goal_position,
  output logic                               at_path_end
);

  localparam int CW  = COORD_WIDTH;
  localparam int IW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int LW  = $clog2(MAX_POINTS + 1);
  localparam int GW  = (IW > plg_pkg::START_W) ? IW : plg_pkg::START_W;
  localparam int NW  = GW + 1;
  localparam int SW  = CW + 1;
  localparam int SQW = 2 * SW;
  localparam int TW  = 2 * plg_pkg::TDIST_W;

  logic signed [CW-1:0] mem_x [MAX_POINTS];
  logic signed [CW-1:0] mem_y [MAX_POINTS];

  logic [LW-1:0]        wp;
  logic [LW-1:0]        path_length;
  logic                 path_valid;
  logic [GW-1:0]        saved_idx;
  logic [GW-1:0]        idx;
  logic signed [CW-1:0] pose_x;
  logic signed [CW-1:0] pose_y;
  logic signed [CW-1:0] rd_x;
  logic signed [CW-1:0] rd_y;
  logic [SW-1:0]        mag_x;
  logic [SW-1:0]        mag_y;
  logic [SQW-1:0]       sq_x;
  logic [SQW-1:0]       sq_y;
  logic [TW-1:0]        t2;

  logic signed [CW-1:0]        in_x;
  logic signed [CW-1:0]        in_y;
  logic                        wp_full;
  logic [LW-1:0]               wp_inc;
  logic [LW-1:0]               last;
  logic [GW-1:0]               load_idx;
  logic [plg_pkg::STEP_W-1:0]  step_eff;
  logic [NW-1:0]               next_idx;
  logic signed [SW-1:0]        dx;
  logic signed [SW-1:0]        dy;
  logic [SQW:0]                sq_sum;

  assign in_x     = coord_x[CW-1:0];
  assign in_y     = coord_y[CW-1:0];
  assign wp_full  = (wp >= LW'(MAX_POINTS));
  assign wp_inc   = wp_full ? wp : wp + 1'b1;
  assign last     = path_length - 1'b1;
  assign load_idx = (NW'(saved_idx) > NW'(last)) ? GW'(last) : saved_idx;
  assign step_eff = (step_size == '0) ? plg_pkg::STEP_W'(1) : step_size;
  assign next_idx = NW'(idx) + NW'(step_eff);
  assign dx       = SW'(rd_x) - SW'(pose_x);
  assign dy       = SW'(rd_y) - SW'(pose_y);
  assign sq_sum   = (SQW + 1)'(sq_x) + (SQW + 1)'(sq_y);

  assign sts.path_valid = path_valid;
  assign sts.too_close  = (sq_x < SQW'(t2)) && (sq_y < SQW'(t2)) &&
                          (sq_sum < (SQW + 1)'(t2));
  assign sts.past_end   = (next_idx >= NW'(path_length));
  assign sts.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.point_wr && !wp_full) begin
      mem_x[wp[IW-1:0]] <= in_x;
      mem_y[wp[IW-1:0]] <= in_y;
    end
    if (cmd.mem_rd) begin
      rd_x <= mem_x[idx[IW-1:0]];
      rd_y <= mem_y[idx[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    mag_x <= dx[SW-1] ? SW'(-dx) : SW'(dx);
    mag_y <= dy[SW-1] ? SW'(-dy) : SW'(dy);
    sq_x  <= mag_x * mag_x;
    sq_y  <= mag_y * mag_y;
    t2    <= target_distance * target_distance;
    if (cmd.pose_load) begin
      pose_x <= in_x;
      pose_y <= in_y;
      idx    <= load_idx;
    end else if (cmd.advance) begin
      idx <= next_idx[GW-1:0];
    end else if (cmd.clamp_last) begin
      idx <= GW'(last);
    end
    if (cmd.emit) begin
      goal_x        <= plg_pkg::OUT_W'(rd_x);
      goal_y        <= plg_pkg::OUT_W'(rd_y);
      goal_position <= idx[plg_pkg::POS_W-1:0];
      at_path_end   <= (NW'(idx) == NW'(last));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp          <= '0;
      path_length <= '0;
      path_valid  <= 1'b0;
      saved_idx   <= GW'(plg_pkg::START_RESET);
      out_valid   <= 1'b0;
    end else begin
      if (cmd.point_wr) begin
        if (path_last) begin
          path_length <= wp_inc;
          path_valid  <= 1'b1;
          wp          <= '0;
        end else begin
          if (wp == '0) begin
            path_valid <= 1'b0;
          end
          wp <= wp_inc;
        end
      end
      if (start_load) begin
        saved_idx <= GW'(start_index);
      end else if (cmd.emit) begin
        saved_idx <= idx;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_valid_length: assert property (@(posedge clk) disable iff (rst)
    path_valid |-> (path_length != '0) && (path_length <= LW'(MAX_POINTS)))
    else $error("Valid path has an impossible length.");

  a_read_in_path: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_rd |-> path_valid && (NW'(idx) < NW'(path_length)))
    else $error("Store read outside the loaded path.");

  a_last_point: assert property (@(posedge clk) disable iff (rst)
    cmd.point_wr && path_last |=> path_valid && (wp == '0))
    else $error("Last point did not close the path.");

  a_emit_index: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid && (goal_position == $past(idx[plg_pkg::POS_W-1:0])))
    else $error("Emitted goal does not match the search index.");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/path_lookahead_goal_selector.sv =====
// Top level: register port, controller and datapath of the lookahead goal selector.
// A path point request is taken while the controller is idle and gives no result.
// A pose request walks the states READ, DIFF, MUL and CMP for each path point examined,
// then FETCH when the search is clamped at the path end, and waits in DONE for a free output.
// Each examined point passes store read, subtract, square and compare in turn.
// Reset is synchronous: path invalid, pointers zero, registers at their defaults.
`default_nettype none

module path_lookahead_goal_selector #(
  parameter int MAX_POINTS  = 1024,
  parameter int COORD_WIDTH = 32
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire                                func,
  input  wire signed [31:0]                  coord_x,
  input  wire signed [31:0]                  coord_y,
  input  wire                                path_last,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic signed [plg_pkg::OUT_W-1:0]   goal_x,
  output logic signed [plg_pkg::OUT_W-1:0]   goal_y,
  output logic [plg_pkg::POS_W-1:0]          goal_position,
  output logic                               at_path_end,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [plg_pkg::PADDR_W-1:0]        paddr,
  input  wire  [plg_pkg::DATA_W-1:0]         pwdata,
  output logic [plg_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  localparam logic [1:0] REG_STEP_SIZE   = 2'd0;
  localparam logic [1:0] REG_TARGET_DIST = 2'd1;
  localparam logic [1:0] REG_START_INDEX = 2'd2;

  localparam logic [plg_pkg::STEP_W-1:0]  STEP_RESET  = 10'd1;
  localparam logic [plg_pkg::TDIST_W-1:0] TDIST_RESET = 31'd65536;

  logic [plg_pkg::STEP_W-1:0]  step_size;
  logic [plg_pkg::TDIST_W-1:0] target_distance;
  logic [plg_pkg::START_W-1:0] start_index;
  logic [1:0]                  reg_sel;
  logic                        reg_wr;
  logic                        start_load;
  plg_pkg::plg_cmd_t           cmd;
  plg_pkg::plg_sts_t           sts;

  assign pready     = 1'b1;
  assign reg_sel    = paddr[3:2];
  assign reg_wr     = psel && penable && pwrite;
  assign start_load = reg_wr && (reg_sel == REG_START_INDEX);

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size       <= STEP_RESET;
      target_distance <= TDIST_RESET;
      start_index     <= plg_pkg::START_RESET;
    end else if (reg_wr) begin
      unique case (reg_sel)
        REG_STEP_SIZE:   step_size       <= pwdata[plg_pkg::STEP_W-1:0];
        REG_TARGET_DIST: target_distance <= pwdata[plg_pkg::TDIST_W-1:0];
        REG_START_INDEX: start_index     <= pwdata[plg_pkg::START_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_STEP_SIZE:   prdata = plg_pkg::DATA_W'(step_size);
      REG_TARGET_DIST: prdata = plg_pkg::DATA_W'(target_distance);
      REG_START_INDEX: prdata = plg_pkg::DATA_W'(start_index);
      default:         prdata = '0;
    endcase
  end

  plg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .sts      (sts),
    .cmd      (cmd)
  );

  plg_dp #(
    .MAX_POINTS  (MAX_POINTS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .coord_x         (coord_x[COORD_WIDTH-1:0]),
    .coord_y         (coord_y[COORD_WIDTH-1:0]),
    .path_last       (path_last),
    .step_size       (step_size),
    .target_distance (target_distance),
    .start_index     (pwdata[plg_pkg::START_W-1:0]),
    .start_load      (start_load),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .goal_x          (goal_x),
    .goal_y          (goal_y),
    .goal_position   (goal_position),
    .at_path_end     (at_path_end)
  );

endmodule

`default_nettype wire
